// ----- rtl/core/b12as_pkg.sv -----
package b12as_pkg;

    localparam int DIGITS = 8;
    localparam int DIG_W  = 4;
    localparam int MAG_W  = 32;
    localparam int RES_W  = 36;

    localparam logic [DIG_W-1:0] RADIX     = 4'd12;
    localparam logic [DIG_W-1:0] MAX_DIGIT = 4'd11;

    typedef enum logic [0:0] {
        OP_ADD = 1'b0,
        OP_SUB = 1'b1
    } t_op;

    typedef struct packed {
        t_op              operation;
        logic             a_negative;
        logic [MAG_W-1:0] a_digits;
        logic             b_negative;
        logic [MAG_W-1:0] b_digits;
    } t_item;

    typedef struct packed {
        logic             result_negative;
        logic [RES_W-1:0] result_digits;
        logic             bad_digit;
    } t_result;

endpackage

// ----- rtl/core/b12as_if.sv -----
interface b12as_in_if;
    import b12as_pkg::*;

    logic             valid;
    logic             ready;
    t_op              operation;
    logic             a_negative;
    logic [MAG_W-1:0] a_digits;
    logic             b_negative;
    logic [MAG_W-1:0] b_digits;

    modport source (
        output valid, operation, a_negative, a_digits, b_negative, b_digits,
        input  ready
    );
    modport sink (
        input  valid, operation, a_negative, a_digits, b_negative, b_digits,
        output ready
    );
endinterface

interface b12as_out_if;
    import b12as_pkg::*;

    logic             valid;
    logic             ready;
    logic             result_negative;
    logic [RES_W-1:0] result_digits;
    logic             bad_digit;

    modport source (
        output valid, result_negative, result_digits, bad_digit,
        input  ready
    );
    modport sink (
        input  valid, result_negative, result_digits, bad_digit,
        output ready
    );
endinterface

// ----- rtl/core/b12as_alu.sv -----
module b12as_alu (
    input  b12as_pkg::t_item   i_item,
    output b12as_pkg::t_result o_result
);
    import b12as_pkg::*;

    logic             bad;
    logic             b_neg_eff;
    logic             a_gt_b;
    logic [MAG_W-1:0] big;
    logic [MAG_W-1:0] sml;
    logic [RES_W-1:0] sum_mag;
    logic [RES_W-1:0] dif_mag;
    logic [RES_W-1:0] mag;
    logic             neg;

    // digit range check over the used nibbles
    always_comb begin
        bad = 1'b0;
        for (int i = 0; i < DIGITS; i++) begin
            if (i_item.a_digits[DIG_W*i +: DIG_W] > MAX_DIGIT ||
                i_item.b_digits[DIG_W*i +: DIG_W] > MAX_DIGIT) begin
                bad = 1'b1;
            end
        end
    end

    assign b_neg_eff = i_item.b_negative ^ (i_item.operation == OP_SUB);
    // packed digits below radix order the same as plain binary
    assign a_gt_b    = i_item.a_digits > i_item.b_digits;
    assign big       = a_gt_b ? i_item.a_digits : i_item.b_digits;
    assign sml       = a_gt_b ? i_item.b_digits : i_item.a_digits;

    // base-12 ripple carry add
    always_comb begin
        logic             carry;
        logic [DIG_W:0]   s;
        carry   = 1'b0;
        sum_mag = '0;
        for (int i = 0; i < DIGITS; i++) begin
            s = {1'b0, i_item.a_digits[DIG_W*i +: DIG_W]}
              + {1'b0, i_item.b_digits[DIG_W*i +: DIG_W]}
              + {{DIG_W{1'b0}}, carry};
            carry = (s >= {1'b0, RADIX});
            if (carry) begin
                s = s - {1'b0, RADIX};
            end
            sum_mag[DIG_W*i +: DIG_W] = s[DIG_W-1:0];
        end
        sum_mag[DIG_W*DIGITS +: DIG_W] = {{(DIG_W-1){1'b0}}, carry};
    end

    // base-12 ripple borrow subtract, larger minus smaller
    always_comb begin
        logic             borrow;
        logic [DIG_W:0]   d;
        borrow  = 1'b0;
        dif_mag = '0;
        for (int i = 0; i < DIGITS; i++) begin
            d = {1'b0, big[DIG_W*i +: DIG_W]} + {1'b0, RADIX}
              - {1'b0, sml[DIG_W*i +: DIG_W]}
              - {{DIG_W{1'b0}}, borrow};
            borrow = (d < {1'b0, RADIX});
            if (!borrow) begin
                d = d - {1'b0, RADIX};
            end
            dif_mag[DIG_W*i +: DIG_W] = d[DIG_W-1:0];
        end
    end

    always_comb begin
        if (i_item.a_negative == b_neg_eff) begin
            mag = sum_mag;
            neg = i_item.a_negative;
        end else begin
            mag = dif_mag;
            neg = a_gt_b ? i_item.a_negative : b_neg_eff;
        end
        if (mag == '0) begin
            neg = 1'b0;
        end
        if (bad) begin
            o_result.result_negative = 1'b0;
            o_result.result_digits   = '0;
        end else begin
            o_result.result_negative = neg;
            o_result.result_digits   = mag;
        end
        o_result.bad_digit = bad;
    end
endmodule

// ----- rtl/core/base12_signed_add_sub.sv -----
// registers: input register, then result register, from input transaction to result valid
// throughput: one transaction per cycle while the sink is ready, set by the single add/subtract
//   pass between the two registers; under output backpressure a full input stage holds
// reset: synchronous active-low i_rst_n empties both stages; payload registers are not reset
module base12_signed_add_sub (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b12as_in_if.sink    i_in,
    b12as_out_if.source o_res
);
    import b12as_pkg::*;

    // stage 1: captured operands
    logic    r_s1_valid, n_s1_valid;
    t_item   r_s1_item,  n_s1_item;
    // stage 2: finished result waiting for the sink
    logic    r_s2_valid, n_s2_valid;
    t_result r_s2_res,   n_s2_res;

    t_result alu_res;
    logic    s2_load;
    logic    s1_adv;
    logic    in_take;

    b12as_alu u_alu (
        .i_item   (r_s1_item),
        .o_result (alu_res)
    );

    // result stage can take a new value when empty or being drained
    assign s2_load = !r_s2_valid || o_res.ready;
    assign s1_adv  = r_s1_valid && s2_load;
    // input stage frees up when empty or when its operands move on
    assign i_in.ready = !r_s1_valid || s2_load;
    assign in_take    = i_in.valid && i_in.ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s1_item  = r_s1_item;
        n_s2_valid = r_s2_valid;
        n_s2_res   = r_s2_res;

        if (s2_load) begin
            n_s2_valid = r_s1_valid;
            n_s2_res   = alu_res;
        end
        if (in_take) begin
            n_s1_valid           = 1'b1;
            n_s1_item.operation  = i_in.operation;
            n_s1_item.a_negative = i_in.a_negative;
            n_s1_item.a_digits   = i_in.a_digits;
            n_s1_item.b_negative = i_in.b_negative;
            n_s1_item.b_digits   = i_in.b_digits;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_s1_item <= n_s1_item;
        r_s2_res  <= n_s2_res;
    end

    assign o_res.valid           = r_s2_valid;
    assign o_res.result_negative = r_s2_res.result_negative;
    assign o_res.result_digits   = r_s2_res.result_digits;
    assign o_res.bad_digit       = r_s2_res.bad_digit;
endmodule

// ----- rtl/core/b12as_checker.sv -----
module b12as_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_out_negative,
    input logic [b12as_pkg::RES_W-1:0]  i_out_digits,
    input logic                         i_out_bad
);
    import b12as_pkg::*;

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a bad digit flags a zero, positive result
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_bad) |-> (i_out_digits == '0 && !i_out_negative))
        else $error("bad digit result not cleared");

    // zero is always positive
    a_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_negative) |-> (i_out_digits != '0))
        else $error("negative zero result");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_digits) && $stable(i_out_negative)
             && $stable(i_out_bad)))
        else $error("stalled result changed");
endmodule

bind base12_signed_add_sub b12as_checker u_b12as_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_negative (o_res.result_negative),
    .i_out_digits   (o_res.result_digits),
    .i_out_bad      (o_res.bad_digit)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import b12as_pkg::*;

    // two register stages between the input and the result transaction
    localparam int PIPE_LATENCY = 2;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int IDLE_PERCENT = 11;

    logic i_clk;
    logic i_rst_n;

    b12as_in_if  in_ch ();
    b12as_out_if res_ch ();

    base12_signed_add_sub dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    // predicted results, oldest first
    t_result pending_sums[$];
    int      mismatch_count = 0;
    // when set neither side idles
    bit      steady_run = 1'b0;

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // the run cannot legitimately take this long
    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic int digit_of(logic [MAG_W-1:0] v, int i);
        return int'(v[i*DIG_W +: DIG_W]);
    endfunction

    // sign-magnitude base-12 sum; subtraction flips the sign of the second operand
    function automatic t_result base12_sum(t_item it);
        t_result          r;
        logic             a_neg;
        logic             b_neg;
        logic [RES_W-1:0] mag;
        logic [MAG_W-1:0] big;
        logic [MAG_W-1:0] tiny;
        int               radix_i;
        int               cmp;
        int               carry;
        int               d;
        int               i;
        r       = '0;
        mag     = '0;
        radix_i = int'(RADIX);
        a_neg   = it.a_negative;
        b_neg   = it.b_negative ^ (it.operation == OP_SUB);

        // any digit above eleven in either operand poisons the result
        for (i = 0; i < DIGITS; i++) begin
            if (digit_of(it.a_digits, i) > int'(MAX_DIGIT) ||
                digit_of(it.b_digits, i) > int'(MAX_DIGIT)) begin
                r.bad_digit = 1'b1;
            end
        end
        if (r.bad_digit) begin
            return r;
        end

        if (a_neg == b_neg) begin
            // like signs: add magnitudes, final carry lands in the ninth digit
            carry = 0;
            for (i = 0; i < DIGITS; i++) begin
                d     = digit_of(it.a_digits, i) + digit_of(it.b_digits, i) + carry;
                carry = (d >= radix_i) ? 1 : 0;
                if (carry != 0) begin
                    d -= radix_i;
                end
                mag[i*DIG_W +: DIG_W] = DIG_W'(d);
            end
            if (carry != 0) begin
                mag[DIGITS*DIG_W] = 1'b1;
            end
            r.result_negative = a_neg;
        end else begin
            // unlike signs: larger magnitude minus smaller, sign of the larger
            cmp = 0;
            for (i = DIGITS - 1; i >= 0 && cmp == 0; i--) begin
                if (digit_of(it.a_digits, i) > digit_of(it.b_digits, i)) begin
                    cmp = 1;
                end else if (digit_of(it.a_digits, i) < digit_of(it.b_digits, i)) begin
                    cmp = -1;
                end
            end
            if (cmp != 0) begin
                big   = (cmp > 0) ? it.a_digits : it.b_digits;
                tiny  = (cmp > 0) ? it.b_digits : it.a_digits;
                carry = 0;
                for (i = 0; i < DIGITS; i++) begin
                    d     = digit_of(big, i) - digit_of(tiny, i) - carry;
                    carry = (d < 0) ? 1 : 0;
                    if (carry != 0) begin
                        d += radix_i;
                    end
                    mag[i*DIG_W +: DIG_W] = DIG_W'(d);
                end
                r.result_negative = (cmp > 0) ? a_neg : b_neg;
            end
        end

        // zero is always positive
        if (mag == '0) begin
            r.result_negative = 1'b0;
        end
        r.result_digits = mag;
        return r;
    endfunction

    // drive one transaction at the falling edge, hold it until accepted
    task automatic send_operands(t_op op, logic a_neg, logic [MAG_W-1:0] a,
                                 logic b_neg, logic [MAG_W-1:0] b);
        t_item it;
        it.operation  = op;
        it.a_negative = a_neg;
        it.a_digits   = a;
        it.b_negative = b_neg;
        it.b_digits   = b;
        @(negedge i_clk);
        // random idle cycles before the transaction
        while (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.operation  = it.operation;
        in_ch.a_negative = it.a_negative;
        in_ch.a_digits   = it.a_digits;
        in_ch.b_negative = it.b_negative;
        in_ch.b_digits   = it.b_digits;
        in_ch.valid      = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        // valid stays high; the next call or the drain lowers it
        pending_sums.push_back(base12_sum(it));
    endtask

    function automatic logic [MAG_W-1:0] random_magnitude();
        logic [MAG_W-1:0] v;
        int               shape;
        int               i;
        v     = '0;
        shape = $urandom_range(9);
        for (i = 0; i < DIGITS; i++) begin
            if (shape == 0) begin
                v[i*DIG_W +: DIG_W] = '0;
            end else if (shape == 1) begin
                // small value, only the low digits used
                if (i < 2) begin
                    v[i*DIG_W +: DIG_W] = DIG_W'($urandom_range(11));
                end
            end else if (shape == 2) begin
                // near the top of the range, long carry chains
                v[i*DIG_W +: DIG_W] = DIG_W'($urandom_range(11, 9));
            end else begin
                v[i*DIG_W +: DIG_W] = DIG_W'($urandom_range(11));
            end
        end
        return v;
    endfunction

    // mostly valid operand pairs, with equal and near-equal magnitudes
    // to exercise the compare, and a few bad digits
    task automatic send_random_operands();
        logic [MAG_W-1:0] a;
        logic [MAG_W-1:0] b;
        int               pick;
        int               k;
        a    = random_magnitude();
        pick = $urandom_range(99);
        if (pick < 15) begin
            b = a;
        end else if (pick < 30) begin
            b = a;
            k = $urandom_range(DIGITS - 1);
            b[k*DIG_W +: DIG_W] = DIG_W'($urandom_range(11));
        end else begin
            b = random_magnitude();
        end
        if ($urandom_range(99) < 5) begin
            k = $urandom_range(DIGITS - 1);
            if ($urandom_range(1) != 0) begin
                a[k*DIG_W +: DIG_W] = DIG_W'($urandom_range(15, 12));
            end else begin
                b[k*DIG_W +: DIG_W] = DIG_W'($urandom_range(15, 12));
            end
        end
        send_operands(t_op'($urandom_range(1)), 1'($urandom_range(1)), a,
                      1'($urandom_range(1)), b);
    endtask

    // zeros, full-scale carry out, long borrow, cancellation
    task automatic test_digit_extremes();
        send_operands(OP_ADD, 1'b0, 32'h0000_0000, 1'b0, 32'h0000_0000);
        // negative zero plus negative zero comes out positive
        send_operands(OP_ADD, 1'b1, 32'h0000_0000, 1'b1, 32'h0000_0000);
        send_operands(OP_ADD, 1'b0, 32'hBBBB_BBBB, 1'b0, 32'hBBBB_BBBB);
        send_operands(OP_ADD, 1'b1, 32'hBBBB_BBBB, 1'b1, 32'h0000_0001);
        send_operands(OP_SUB, 1'b0, 32'h1000_0000, 1'b0, 32'h0000_0001);
        // equal magnitudes of unlike sign cancel to positive zero
        send_operands(OP_SUB, 1'b0, 32'h5A3B_0719, 1'b0, 32'h5A3B_0719);
    endtask

    // every operation with every sign pair, plus the smaller-first cases
    task automatic test_sign_combinations();
        int combo;
        for (combo = 0; combo < 8; combo++) begin
            send_operands(t_op'(combo[2]), combo[1], 32'h0000_0B57, combo[0], 32'h0000_0A99);
        end
        send_operands(OP_ADD, 1'b0, 32'h0000_0A99, 1'b1, 32'h0000_0B57);
        send_operands(OP_SUB, 1'b1, 32'h0000_0A99, 1'b1, 32'h0B57_0000);
    endtask

    // digits twelve to fifteen in low, high and middle nibbles of each operand
    task automatic test_bad_digits();
        send_operands(OP_ADD, 1'b0, 32'h0000_000C, 1'b0, 32'h0000_0001);
        send_operands(OP_ADD, 1'b1, 32'h0000_0001, 1'b0, 32'hF000_0000);
        send_operands(OP_SUB, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_operands(OP_SUB, 1'b0, 32'hBBBB_BBBD, 1'b1, 32'h0000_0000);
        send_operands(OP_ADD, 1'b1, 32'h1234_5678, 1'b1, 32'h000E_0000);
    endtask

    task automatic test_random_mix(int count);
        int n;
        for (n = 0; n < count; n++) begin
            send_random_operands();
        end
    endtask

    // full rate on both sides, no idle cycles at all
    task automatic test_back_to_back(int count);
        int n;
        steady_run = 1'b1;
        for (n = 0; n < count; n++) begin
            send_random_operands();
        end
        steady_run = 1'b0;
    endtask

    // result side ready, idles at random outside the steady stretch
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready = steady_run || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // compare each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_sums.size() == 0) begin
                flag_mismatch("unexpected result", 64'({res_ch.result_negative,
                              res_ch.result_digits, res_ch.bad_digit}), '0);
            end else begin
                want = pending_sums.pop_front();
                if (res_ch.bad_digit !== want.bad_digit) begin
                    flag_mismatch("bad_digit", 64'(res_ch.bad_digit),
                                  64'(want.bad_digit));
                end
                if (res_ch.result_negative !== want.result_negative) begin
                    flag_mismatch("result_negative", 64'(res_ch.result_negative),
                                  64'(want.result_negative));
                end
                if (res_ch.result_digits !== want.result_digits) begin
                    flag_mismatch("result_digits", 64'(res_ch.result_digits),
                                  64'(want.result_digits));
                end
            end
        end
    end

    initial begin
        int drain_cycles;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.operation  = OP_ADD;
        in_ch.a_negative = 1'b0;
        in_ch.a_digits   = '0;
        in_ch.b_negative = 1'b0;
        in_ch.b_digits   = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_digit_extremes();
        test_sign_combinations();
        test_bad_digits();
        test_random_mix(700);
        test_back_to_back(300);
        test_random_mix(600);

        // stop sending and let the pipeline empty
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        drain_cycles = 0;
        while (pending_sums.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (PIPE_LATENCY + 3) @(posedge i_clk);
        if (pending_sums.size() != 0) begin
            flag_mismatch("results never arrived", 64'(pending_sums.size()), '0);
        end

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/b12as_pkg.sv
rtl/core/b12as_if.sv
rtl/core/b12as_alu.sv
rtl/core/base12_signed_add_sub.sv
rtl/core/b12as_checker.sv
tb/sv/testbench.sv
